// ----- hdl/pftr_pkg.sv -----
`default_nettype none

package pftr_pkg;

  // Default display geometry in pixels
  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;

  // Request codes
  localparam logic [2:0] REQ_CURSOR = 3'd0;
  localparam logic [2:0] REQ_PIXEL  = 3'd1;
  localparam logic [2:0] REQ_GLYPH  = 3'd2;
  localparam logic [2:0] REQ_FILL   = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_GLYPH_WIDTH  = 1'b0;
  localparam logic CFG_GLYPH_HEIGHT = 1'b1;

  // Configuration reset values
  localparam logic [4:0] GLYPH_WIDTH_RST  = 5'd7;
  localparam logic [5:0] GLYPH_HEIGHT_RST = 6'd10;

  // Printable character range
  localparam logic [7:0] FIRST_CHAR = 8'd32;
  localparam logic [7:0] LAST_CHAR  = 8'd126;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the request fields
    logic set_cur;  // load the cursor from the request ports
    logic pix_rd;   // read the byte under the pixel, write it back next cycle
    logic gly_rd;   // read the byte under the current glyph column, advance column
    logic gly_chk;  // record the glyph reject flag
    logic adv;      // advance the cursor on the last glyph row
    logic byte_rd;  // read one byte for the result
    logic sw_clr;   // restart the sweep address
    logic sw_wr;    // write the sweep byte and advance
    logic sw_fill;  // sweep writes the fill color instead of zero
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic glyph_bad;
    logic gw_zero;
    logic col_last;
    logic sw_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/page_framebuffer_text_renderer_core.sv -----
`default_nettype none

// Page-organized monochrome framebuffer with a text cursor. A request is taken
// when start_i is high and busy_o is low; exactly one result word follows, on
// status_o, read_value_o and cursor_column_o, valid only in the single cycle
// that done_o is high. The receiver cannot stall, so it must capture that word
// in that cycle. A set cursor request and unknown codes go straight to the
// result; a draw pixel or read byte request makes one memory read first; a
// glyph row is checked first and, if accepted and of nonzero width, then
// streams its columns; a fill writes all FB_BYTES bytes, where FB_BYTES =
// DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8). The frame memory has a single
// read-modify-write path: a glyph row streams one column per cycle, with the
// write-back of each column overlapping the read of the next, and a fill
// writes one byte per cycle. After reset the block clears every byte of the
// frame memory one byte per cycle and holds busy_o high until it is done;
// configuration writes are taken at any time but belong only to idle periods.

module page_framebuffer_text_renderer_core
  import pftr_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [5:0]  cfg_data_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  pos_x_i,
  input  wire logic [7:0]  pos_y_i,
  input  wire logic        color_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [4:0]  row_index_i,
  input  wire logic [15:0] row_bits_i,
  input  wire logic        last_row_i,
  input  wire logic [9:0]  byte_index_i,
  output logic             done_o,
  output logic             status_o,
  output logic [7:0]       read_value_o,
  output logic [7:0]       cursor_column_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequence requests
  pftr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .done_o     (done_o)
  );

  // Hold the frame memory, cursor and configuration
  pftr_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .color_i         (color_i),
    .char_code_i     (char_code_i),
    .row_index_i     (row_index_i),
    .row_bits_i      (row_bits_i),
    .last_row_i      (last_row_i),
    .byte_index_i    (byte_index_i),
    .stat_o          (stat),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .cursor_column_o (cursor_column_o)
  );

endmodule

`default_nettype wire

// ----- hdl/pftr_ctrl.sv -----
`default_nettype none

module pftr_ctrl
  import pftr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] req_type_i,
  input  wire dp_stat_t   stat_i,
  output ctrl_cmd_t       cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PIX   = 3'd2;
  localparam logic [2:0] ST_GCHK  = 3'd3;
  localparam logic [2:0] ST_GRUN  = 3'd4;
  localparam logic [2:0] ST_RBYTE = 3'd5;
  localparam logic [2:0] ST_FILL  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  // Sequence one request
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.sw_wr = 1'b1;
        if (stat_i.sw_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (req_type_i)
            REQ_CURSOR: begin
              cmd_o.set_cur = 1'b1;
              state_d       = ST_DONE;
            end
            REQ_PIXEL: state_d = ST_PIX;
            REQ_GLYPH: state_d = ST_GCHK;
            REQ_FILL: begin
              cmd_o.sw_clr = 1'b1;
              state_d      = ST_FILL;
            end
            REQ_READ: state_d = ST_RBYTE;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_PIX: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = ST_DONE;
      end
      ST_GCHK: begin
        cmd_o.gly_chk = 1'b1;
        if (stat_i.glyph_bad || stat_i.gw_zero) state_d = ST_DONE;
        else state_d = ST_GRUN;
      end
      ST_GRUN: begin
        cmd_o.gly_rd = 1'b1;
        if (stat_i.col_last) begin
          cmd_o.adv = 1'b1;
          state_d   = ST_DONE;
        end
      end
      ST_RBYTE: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = ST_DONE;
      end
      ST_FILL: begin
        cmd_o.sw_wr   = 1'b1;
        cmd_o.sw_fill = 1'b1;
        if (stat_i.sw_last) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLR;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ----- hdl/pftr_datapath.sv -----
`default_nettype none

module pftr_datapath
  import pftr_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [5:0]  cfg_data_i,
  input  wire ctrl_cmd_t   cmd_i,
  input  wire logic [7:0]  pos_x_i,
  input  wire logic [7:0]  pos_y_i,
  input  wire logic        color_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [4:0]  row_index_i,
  input  wire logic [15:0] row_bits_i,
  input  wire logic        last_row_i,
  input  wire logic [9:0]  byte_index_i,
  output dp_stat_t         stat_o,
  output logic             status_o,
  output logic [7:0]       read_value_o,
  output logic [7:0]       cursor_column_o
);

  localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
  localparam int FB_BYTES   = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW         = $clog2(FB_BYTES);

  // Configuration and cursor
  logic [4:0] gw_q;
  logic [5:0] gh_q;
  logic [7:0] cur_col_q, cur_row_q;

  // Latched request fields
  logic [7:0]  pos_x_q, pos_y_q, char_q;
  logic        color_q, last_q;
  logic [4:0]  row_idx_q;
  logic [15:0] row_bits_q;
  logic [9:0]  byte_idx_q;

  // Sequencing state
  logic [4:0]    col_q;
  logic [AW-1:0] sw_q;
  logic          status_q, rd_hit_q;

  // Pending write-back of a read-modify-write
  logic          p_vld_q, p_vld_d;
  logic [AW-1:0] p_addr_q, p_addr_d;
  logic [2:0]    p_bit_q, p_bit_d;
  logic          p_val_q, p_val_d;

  // Frame memory
  logic [7:0]    mem [FB_BYTES];
  logic [7:0]    rdata_q;
  logic          re;
  logic [AW-1:0] raddr;

  // Address arithmetic
  logic [8:0]  px_ext, py_ext, gx, gy;
  logic [15:0] pix_addr, gly_addr, byte_ext;
  logic        pix_in, gly_in, byte_in, gly_on;
  logic [9:0]  fit_x, fit_y;
  logic [7:0]  fill_byte, wmask;

  assign px_ext   = {1'b0, pos_x_q};
  assign py_ext   = {1'b0, pos_y_q};
  assign pix_in   = (px_ext < 9'(DISPLAY_WIDTH)) && (py_ext < 9'(DISPLAY_HEIGHT));
  assign pix_addr = 16'(px_ext) + 16'(py_ext[8:3]) * 16'(DISPLAY_WIDTH);

  assign gx       = {1'b0, cur_col_q} + {4'b0, col_q};
  assign gy       = {1'b0, cur_row_q} + {4'b0, row_idx_q};
  assign gly_in   = (gx < 9'(DISPLAY_WIDTH)) && (gy < 9'(DISPLAY_HEIGHT));
  assign gly_addr = 16'(gx) + 16'(gy[8:3]) * 16'(DISPLAY_WIDTH);
  assign gly_on   = (col_q < 5'd16) && row_bits_q[~col_q[3:0]];

  assign byte_ext = 16'(byte_idx_q);
  assign byte_in  = byte_ext < 16'(FB_BYTES);

  // Glyph fit and character checks
  assign fit_x = {2'b0, cur_col_q} + {5'b0, gw_q};
  assign fit_y = {2'b0, cur_row_q} + {4'b0, gh_q};

  always_comb begin
    stat_o.glyph_bad = (char_q < FIRST_CHAR) || (char_q > LAST_CHAR) ||
                       (fit_x > 10'(DISPLAY_WIDTH)) || (fit_y > 10'(DISPLAY_HEIGHT));
    stat_o.gw_zero   = (gw_q == 5'd0);
    stat_o.col_last  = (col_q == gw_q - 5'd1);
    stat_o.sw_last   = (sw_q == AW'(FB_BYTES - 1));
  end

  // Select the read address and the pending write
  always_comb begin
    re       = 1'b0;
    raddr    = '0;
    p_vld_d  = 1'b0;
    p_addr_d = p_addr_q;
    p_bit_d  = p_bit_q;
    p_val_d  = p_val_q;
    priority if (cmd_i.pix_rd) begin
      re       = 1'b1;
      raddr    = pix_addr[AW-1:0];
      p_vld_d  = pix_in;
      p_addr_d = pix_addr[AW-1:0];
      p_bit_d  = pos_y_q[2:0];
      p_val_d  = color_q;
    end else if (cmd_i.gly_rd) begin
      re       = 1'b1;
      raddr    = gly_addr[AW-1:0];
      p_vld_d  = gly_in;
      p_addr_d = gly_addr[AW-1:0];
      p_bit_d  = gy[2:0];
      p_val_d  = gly_on ? color_q : ~color_q;
    end else if (cmd_i.byte_rd) begin
      re    = 1'b1;
      raddr = byte_ext[AW-1:0];
    end else begin
      // No read this cycle
      re = 1'b0;
    end
  end

  assign fill_byte = (cmd_i.sw_fill && color_q) ? 8'hFF : 8'h00;
  assign wmask     = 8'(1) << p_bit_q;

  // Read, modify and write the frame memory
  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[raddr];
    if (p_vld_q) begin
      mem[p_addr_q] <= p_val_q ? (rdata_q | wmask) : (rdata_q & ~wmask);
    end else if (cmd_i.sw_wr) begin
      mem[sw_q] <= fill_byte;
    end
  end

  // Hold the pending write-back slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= p_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_addr_q <= p_addr_d;
    p_bit_q  <= p_bit_d;
    p_val_q  <= p_val_d;
  end

  // Latch the request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q    <= pos_x_i;
      pos_y_q    <= pos_y_i;
      color_q    <= color_i;
      char_q     <= char_code_i;
      row_idx_q  <= row_index_i;
      row_bits_q <= row_bits_i;
      last_q     <= last_row_i;
      byte_idx_q <= byte_index_i;
    end
  end

  // Configuration, cursor, counters and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q      <= GLYPH_WIDTH_RST;
      gh_q      <= GLYPH_HEIGHT_RST;
      cur_col_q <= '0;
      cur_row_q <= '0;
      col_q     <= '0;
      sw_q      <= '0;
      status_q  <= 1'b0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GLYPH_WIDTH:  gw_q <= cfg_data_i[4:0];
          CFG_GLYPH_HEIGHT: gh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.set_cur) begin
        cur_col_q <= pos_x_i;
        cur_row_q <= pos_y_i;
      end else if (cmd_i.adv && last_q) begin
        cur_col_q <= cur_col_q + {3'b0, gw_q};
      end
      if (cmd_i.load) begin
        col_q    <= '0;
        status_q <= 1'b0;
        rd_hit_q <= 1'b0;
      end else begin
        if (cmd_i.gly_rd) col_q <= col_q + 5'd1;
        if (cmd_i.gly_chk) status_q <= stat_o.glyph_bad;
        if (cmd_i.byte_rd) rd_hit_q <= byte_in;
      end
      if (cmd_i.sw_clr) sw_q <= '0;
      else if (cmd_i.sw_wr) sw_q <= sw_q + AW'(1);
    end
  end

  assign status_o        = status_q;
  assign read_value_o    = rd_hit_q ? rdata_q : 8'h00;
  assign cursor_column_o = cur_col_q;

endmodule

`default_nettype wire

// ----- tb/sv/page_framebuffer_text_renderer_core_tb.sv -----
module page_framebuffer_text_renderer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pftr_pkg::*;

  localparam int DISP_W          = DISPLAY_WIDTH_DEF;
  localparam int DISP_H          = DISPLAY_HEIGHT_DEF;
  localparam int FB_BYTES        = DISP_W * ((DISP_H + 7) / 8);
  localparam int STALL_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 40;
  localparam int WORDS_PER_PHASE = 500;
  localparam int WORDS_PER_SIZE  = 100;

  // One request word as the driver sees it
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        color;
    logic [7:0]  ch;
    logic [4:0]  row;
    logic [15:0] bits;
    logic        last;
    logic [9:0]  addr;
  } draw_req_t;

  // One result word
  typedef struct packed {
    logic       status;
    logic [7:0] rd;
    logic [7:0] col;
  } result_word_t;

  // Shadow framebuffer, cursor and glyph size; queue of result words still owed
  class frame_scoreboard;
    logic [7:0]   frame [FB_BYTES];
    logic [7:0]   cur_col;
    logic [7:0]   cur_row;
    logic [4:0]   gw;
    logic [5:0]   gh;
    result_word_t pending [$];
    int           errors;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      cur_col = '0;
      cur_row = '0;
      gw      = GLYPH_WIDTH_RST;
      gh      = GLYPH_HEIGHT_RST;
      errors  = 0;
    endfunction

    function void set_reg(logic idx, logic [5:0] data);
      if (idx == CFG_GLYPH_WIDTH) begin
        gw = data[4:0];
      end else begin
        gh = data;
      end
    endfunction

    // Drop pixels off the display, else set or clear one bit of its page byte
    function void put_dot(int x, int y, logic white);
      int addr;
      if (x >= DISP_W || y >= DISP_H) return;
      addr = x + (y / 8) * DISP_W;
      if (addr >= FB_BYTES) return;
      frame[addr][y % 8] = white;
    endfunction

    // Apply one accepted word to the shadow state and queue its result
    function void note_request(draw_req_t r);
      result_word_t w;
      logic         on;
      w = '0;
      case (r.kind)
        REQ_CURSOR: begin
          cur_col = r.x;
          cur_row = r.y;
        end
        REQ_PIXEL: put_dot(int'(r.x), int'(r.y), r.color);
        REQ_GLYPH: begin
          if (r.ch < FIRST_CHAR || r.ch > LAST_CHAR ||
              int'(cur_col) + int'(gw) > DISP_W ||
              int'(cur_row) + int'(gh) > DISP_H) begin
            w.status = 1'b1;
          end else begin
            for (int j = 0; j < int'(gw); j++) begin
              on = (j < 16) ? r.bits[15 - j] : 1'b0;
              put_dot(int'(cur_col) + j, int'(cur_row) + int'(r.row), on ? r.color : ~r.color);
            end
            if (r.last) cur_col = cur_col + 8'(gw);
          end
        end
        REQ_FILL: foreach (frame[i]) frame[i] = {8{r.color}};
        REQ_READ: if (int'(r.addr) < FB_BYTES) w.rd = frame[r.addr];
        default: ;
      endcase
      w.col = cur_col;
      pending.push_back(w);
    endfunction

    // Compare one result word with the oldest one owed
    function void check_word(logic st, logic [7:0] rd, logic [7:0] col);
      result_word_t w;
      if (pending.size() == 0) begin
        $error("result word with none owed: status %0d read_value %02h cursor_column %0d",
               st, rd, col);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, st);
        errors++;
      end
      if (rd !== w.rd) begin
        $error("read_value: expected %02h, got %02h", w.rd, rd);
        errors++;
      end
      if (col !== w.col) begin
        $error("cursor_column: expected %0d, got %0d", w.col, col);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [5:0]  cfg_data_i;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  req_type_i;
  logic [7:0]  pos_x_i;
  logic [7:0]  pos_y_i;
  logic        color_i;
  logic [7:0]  char_code_i;
  logic [4:0]  row_index_i;
  logic [15:0] row_bits_i;
  logic        last_row_i;
  logic [9:0]  byte_index_i;
  logic        done_o;
  logic        status_o;
  logic [7:0]  read_value_o;
  logic [7:0]  cursor_column_o;

  frame_scoreboard sb;
  int              idle_pct;
  int              words_sent;
  int              stall_cycles = 0;

  page_framebuffer_text_renderer_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every result word in the cycle it is shown
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_word(status_o, read_value_o, cursor_column_o);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("page_framebuffer_text_renderer_core_tb NOT OK");
      $finish;
    end
  end

  // Random content in every field, the kind set by the caller
  function automatic draw_req_t blank_req(logic [2:0] kind);
    draw_req_t r;
    r.kind  = kind;
    r.x     = 8'($urandom);
    r.y     = 8'($urandom);
    r.color = 1'($urandom);
    r.ch    = 8'($urandom);
    r.row   = 5'($urandom);
    r.bits  = 16'($urandom);
    r.last  = 1'($urandom);
    r.addr  = 10'($urandom);
    return r;
  endfunction

  // Idle a random number of cycles, then hold the word until it is taken
  task automatic send_word(draw_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    req_type_i   <= r.kind;
    pos_x_i      <= r.x;
    pos_y_i      <= r.y;
    color_i      <= r.color;
    char_code_i  <= r.ch;
    row_index_i  <= r.row;
    row_bits_i   <= r.bits;
    last_row_i   <= r.last;
    byte_index_i <= r.addr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(r);
    words_sent++;
  endtask

  task automatic do_cursor(int x, int y);
    draw_req_t r;
    r   = blank_req(REQ_CURSOR);
    r.x = 8'(x);
    r.y = 8'(y);
    send_word(r);
  endtask

  task automatic do_pixel(int x, int y, logic color);
    draw_req_t r;
    r       = blank_req(REQ_PIXEL);
    r.x     = 8'(x);
    r.y     = 8'(y);
    r.color = color;
    send_word(r);
  endtask

  task automatic do_glyph(int ch, int row, logic [15:0] bits, logic color, logic last);
    draw_req_t r;
    r       = blank_req(REQ_GLYPH);
    r.ch    = 8'(ch);
    r.row   = 5'(row);
    r.bits  = bits;
    r.color = color;
    r.last  = last;
    send_word(r);
  endtask

  task automatic do_fill(logic color);
    draw_req_t r;
    r       = blank_req(REQ_FILL);
    r.color = color;
    send_word(r);
  endtask

  task automatic do_read(int addr);
    draw_req_t r;
    r      = blank_req(REQ_READ);
    r.addr = 10'(addr);
    send_word(r);
  endtask

  // Hold off new words until every result has come and the block is idle
  task automatic drain_words();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  // Write both glyph size registers, width first, then height
  task automatic load_glyph_size(logic [5:0] w_data, logic [5:0] h_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_GLYPH_WIDTH;
    cfg_data_i <= w_data;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GLYPH_HEIGHT;
    cfg_data_i <= h_data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(CFG_GLYPH_WIDTH, w_data);
    sb.set_reg(CFG_GLYPH_HEIGHT, h_data);
  endtask

  initial begin
    int   target, stop, sel, w, h, nchar, rows, base_x, rx, ry, ch, x, y, n;
    logic color;
    int   width_edge [5];
    int   height_edge [5];
    width_edge  = '{0, 1, 16, 17, 31};
    height_edge = '{0, 1, 32, 33, 63};
    sb           = new();
    words_sent   = 0;
    idle_pct     = 27;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_GLYPH_WIDTH;
    cfg_data_i   = '0;
    start_i      = 1'b0;
    req_type_i   = REQ_CURSOR;
    pos_x_i      = '0;
    pos_y_i      = '0;
    color_i      = 1'b0;
    char_code_i  = '0;
    row_index_i  = '0;
    row_bits_i   = '0;
    last_row_i   = 1'b0;
    byte_index_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Cleared buffer at both ends
    do_read(0);
    do_read(FB_BYTES - 1);
    // Glyph rows at the home position, set bits and inverse color
    do_glyph(65, 0, 16'hFFFF, 1'b1, 1'b0);
    do_glyph(FIRST_CHAR, 9, 16'h0000, 1'b0, 1'b1);
    do_read(1);
    do_read(2 + DISP_W);
    // Characters just outside the printable range
    do_glyph(FIRST_CHAR - 1, 0, 16'hFFFF, 1'b1, 1'b1);
    do_glyph(LAST_CHAR + 1, 0, 16'hFFFF, 1'b1, 1'b1);
    do_glyph(LAST_CHAR, 31, 16'hA5A5, 1'b1, 1'b1);
    // Glyph touching the right and bottom edges, then no room left
    do_cursor(DISP_W - 7, DISP_H - 10);
    do_glyph(LAST_CHAR, 9, 16'h8001, 1'b1, 1'b1);
    do_read(FB_BYTES - 1);
    do_glyph(64, 0, 16'hFFFF, 1'b1, 1'b1);
    do_cursor(0, DISP_H - 9);
    do_glyph(65, 0, 16'hFFFF, 1'b1, 1'b1);
    do_cursor(255, 255);
    // Pixels at the corner and off the display
    do_pixel(DISP_W - 1, DISP_H - 1, 1'b0);
    do_read(FB_BYTES - 1);
    do_pixel(DISP_W, 0, 1'b1);
    do_pixel(0, DISP_H, 1'b1);
    do_pixel(255, 255, 1'b1);
    do_pixel(0, 0, 1'b0);
    do_read(0);
    // Fill both ways
    do_fill(1'b1);
    do_read(FB_BYTES / 2);
    do_fill(1'b0);
    do_read(FB_BYTES / 2);
    // Codes past the last request type do nothing
    for (int k = REQ_READ + 1; k < 8; k++) send_word(blank_req(3'(k)));

    // Zero width: nothing drawn, cursor stays
    drain_words();
    load_glyph_size(6'd0, 6'(GLYPH_HEIGHT_RST));
    do_cursor(10, 0);
    do_glyph(65, 0, 16'hFFFF, 1'b1, 1'b1);
    do_read(10);
    // Widest row the bit pattern covers, one row high, at the bottom right
    drain_words();
    load_glyph_size(6'd16, 6'd1);
    do_cursor(DISP_W - 16, DISP_H - 1);
    do_glyph(66, 0, 16'h8001, 1'b1, 1'b1);
    do_read(DISP_W - 16 + 7 * DISP_W);
    do_read(DISP_W - 1 + 7 * DISP_W);
    // Columns past sixteen take the inverse color
    drain_words();
    load_glyph_size(6'd31, 6'd63);
    do_cursor(0, 1);
    do_glyph(67, 31, 16'hFFFF, 1'b1, 1'b1);
    do_read(20 + 4 * DISP_W);
    do_read(15 + 4 * DISP_W);
    do_glyph(68, 0, 16'h0F0F, 1'b0, 1'b1);
    // Upper data bit dropped by the width register, zero height
    drain_words();
    load_glyph_size(6'd39, 6'd0);
    do_cursor(DISP_W - 7, DISP_H);
    do_glyph(70, 0, 16'hFFFF, 1'b1, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 27 : (phase == 1) ? 63 : 0;
      target   = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) begin
        // New glyph size, now and then an edge value
        drain_words();
        w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : width_edge[$urandom_range(0, 4)];
        h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 32) : height_edge[$urandom_range(0, 4)];
        load_glyph_size({1'($urandom), 5'(w)}, 6'(h));
        stop = words_sent + WORDS_PER_SIZE;
        while (words_sent < stop && words_sent < target) begin
          sel = $urandom_range(0, 99);
          if (sel < 60) begin
            // Place the cursor where a glyph fits, now and then anywhere
            if ($urandom_range(0, 9) == 0) begin
              do_cursor($urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
              x = DISP_W - int'(sb.gw);
              y = DISP_H - int'(sb.gh);
              do_cursor($urandom_range(0, (x > 0) ? x : 0), $urandom_range(0, (y > 0) ? y : 0));
            end
            // Draw a few characters row by row
            rows  = (sb.gh == 0) ? 1 : int'(sb.gh);
            nchar = $urandom_range(1, 4);
            for (int c = 0; c < nchar; c++) begin
              ch = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(FIRST_CHAR, LAST_CHAR);
              color  = 1'($urandom);
              base_x = int'(sb.cur_col);
              for (int r = 0; r < rows; r++) begin
                do_glyph(ch, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : r,
                         16'($urandom), color,
                         ($urandom_range(0, 29) == 0) ? 1'($urandom) : (r == rows - 1));
              end
              // Look back at one byte under the glyph just drawn
              if ($urandom_range(0, 1) == 0) begin
                rx = base_x + $urandom_range(0, (sb.gw > 0) ? int'(sb.gw) - 1 : 0);
                ry = int'(sb.cur_row) + $urandom_range(0, rows - 1);
                do_read(rx + (ry / 8) * DISP_W);
              end
            end
          end else if (sel < 72) begin
            // A burst of pixels, mostly on the display, then read the last one back
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
              x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, DISP_W - 1);
              y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, DISP_H - 1);
              do_pixel(x, y, 1'($urandom));
            end
            do_read(x + (y / 8) * DISP_W);
          end else if (sel < 80) begin
            do_read($urandom_range(0, FB_BYTES - 1));
          end else if (sel < 81) begin
            do_fill(1'($urandom));
          end else begin
            send_word(blank_req(3'($urandom_range(0, 7))));
          end
          if ($urandom_range(0, 99) == 0) drain_words();
        end
      end
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("page_framebuffer_text_renderer_core_tb OK");
    end else begin
      $display("page_framebuffer_text_renderer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
